/* hw/rtl/rgba_summed_area_table_unit_defines.svh */
// ----------------------------------------------------------------------------
// rgba summed area table unit - assertion macros
// Concurrent assertion helpers; defining ASSERT_OFF compiles them away.
// ----------------------------------------------------------------------------
`ifndef RGBA_SUMMED_AREA_TABLE_UNIT_DEFINES_SVH
`define RGBA_SUMMED_AREA_TABLE_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define RSAT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rgbasat same-cycle check failed");
`define RSAT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rgbasat next-cycle check failed");
`else
`define RSAT_ASSERT_IMP(lbl, ante, cons)
`define RSAT_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

/* hw/rtl/rgbasat_pkg.sv */
// ----------------------------------------------------------------------------
// rgbasat_pkg
// Shared types and codes of the rgba summed area table unit.
// ----------------------------------------------------------------------------
package rgbasat_pkg;

  localparam int CW      = 9;   // coordinate width
  localparam int LANE_W  = 24;  // table word per channel
  localparam int RSUM_W  = 16;  // running row sum per channel
  localparam int NCH     = 4;
  localparam int AREA_W  = 18;
  localparam int DIV_STEPS = 24;
  localparam int Q_DEPTH = 2;
  localparam int QPW     = 1;

  localparam logic [1:0] FUNC_LOAD = 2'd0;
  localparam logic [1:0] FUNC_AVG  = 2'd1;
  localparam logic [1:0] FUNC_SUM  = 2'd2;
  localparam logic [1:0] FUNC_RSVD = 2'd3;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_ZERO_AREA  = 2'd1;
  localparam logic [1:0] ST_RANGE      = 2'd2;
  localparam logic [1:0] ST_NOT_LOADED = 2'd3;

  typedef logic [NCH-1:0][LANE_W-1:0] lane_arr_t;

  // decoded work item; loads use x0/y0 as the write position
  typedef struct packed {
    logic [1:0]        func;
    logic [1:0]        status;
    logic [31:0]       pixel;
    logic [CW-1:0]     x0;
    logic [CW-1:0]     xa1;
    logic [CW-1:0]     xb1;
    logic [CW-1:0]     y0;
    logic [CW-1:0]     y1;
    logic              split;
    logic [AREA_W-1:0] area;
  } cmd_t;

  typedef struct packed {
    logic          loaded;
    logic [CW-1:0] col;
    logic [CW-1:0] row;
  } front_stat_t;

endpackage

/* hw/rtl/rgbasat_front.sv */
// ----------------------------------------------------------------------------
// rgbasat_front
// Accepts items, tracks the load position and classifies queries.
// ----------------------------------------------------------------------------
module rgbasat_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                func,
  input  logic [31:0]               pixel,
  input  logic signed [8:0]         query_x,
  input  logic [8:0]                query_y,
  input  logic [8:0]                query_width,
  input  logic [8:0]                query_height,
  input  logic [8:0]                region_width,
  input  logic [8:0]                region_height,
  input  logic                      cfg_wr,
  input  logic                      q_full,
  output logic                      q_push,
  output rgbasat_pkg::cmd_t         q_data,
  output rgbasat_pkg::front_stat_t  stat
);
  import rgbasat_pkg::*;

  logic          loaded;
  logic [CW-1:0] load_col;
  logic [CW-1:0] load_row;
  logic          accept;
  logic          is_load;
  logic [10:0]   qx_w;
  logic [9:0]    x1;
  logic [9:0]    ybot;
  logic          range_bad;
  logic [1:0]    st;
  logic          split;
  logic [9:0]    col_inc;
  logic [9:0]    row_inc;

  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;
  assign is_load  = (func == FUNC_LOAD);
  assign q_push   = accept && (func != FUNC_RSVD);

  always_comb begin
    // negative left column wraps from the right edge
    qx_w = {{2{query_x[8]}}, query_x} + (query_x[8] ? {2'b00, region_width} : 11'd0);
    ybot = {1'b0, query_y} + {1'b0, query_height};
    range_bad = qx_w[10] || (qx_w[9:0] >= {1'b0, region_width}) ||
                (query_width > region_width) || (ybot > {1'b0, region_height});
    if (!loaded) begin
      st = ST_NOT_LOADED;
    end else if (query_width == 9'd0 || query_height == 9'd0) begin
      st = ST_ZERO_AREA;
    end else if (range_bad) begin
      st = ST_RANGE;
    end else begin
      st = ST_OK;
    end
    x1    = {1'b0, qx_w[8:0]} + {1'b0, query_width};
    split = x1 > {1'b0, region_width};

    q_data.func   = func;
    q_data.status = is_load ? ST_OK : st;
    q_data.pixel  = pixel;
    q_data.x0     = is_load ? load_col : qx_w[8:0];
    q_data.xa1    = split ? region_width : x1[8:0];
    q_data.xb1    = 9'(x1 - {1'b0, region_width});
    q_data.y0     = is_load ? load_row : query_y;
    q_data.y1     = ybot[8:0];
    q_data.split  = split;
    q_data.area   = AREA_W'(query_width) * AREA_W'(query_height);
  end

  assign col_inc = {1'b0, load_col} + 10'd1;
  assign row_inc = {1'b0, load_row} + 10'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded   <= 1'b0;
      load_col <= '0;
      load_row <= '0;
    end else if (cfg_wr) begin
      loaded   <= 1'b0;
      load_col <= '0;
      load_row <= '0;
    end else if (accept && is_load) begin
      loaded <= 1'b0;
      if (col_inc >= {1'b0, region_width}) begin
        load_col <= '0;
        if (row_inc >= {1'b0, region_height}) begin
          load_row <= '0;
          loaded   <= 1'b1;
        end else begin
          load_row <= row_inc[8:0];
        end
      end else begin
        load_col <= col_inc[8:0];
      end
    end
  end

  assign stat.loaded = loaded;
  assign stat.col    = load_col;
  assign stat.row    = load_row;

endmodule

/* hw/rtl/rgbasat_fifo.sv */
// ----------------------------------------------------------------------------
// rgbasat_fifo
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module rgbasat_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  rgbasat_pkg::cmd_t  wdata,
  output logic               full,
  input  logic               pop,
  output logic               valid,
  output rgbasat_pkg::cmd_t  rdata
);
  import rgbasat_pkg::*;

  cmd_t           ent [Q_DEPTH];
  logic [QPW-1:0] wp;
  logic [QPW-1:0] rp;
  logic [QPW:0]   cnt;

  assign full  = (cnt == (QPW+1)'(Q_DEPTH));
  assign valid = (cnt != '0);
  assign rdata = ent[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wp] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      wp  <= wp + QPW'(push);
      rp  <= rp + QPW'(pop);
      cnt <= cnt + {{QPW{1'b0}}, push} - {{QPW{1'b0}}, pop};
    end
  end

endmodule

/* hw/rtl/rgbasat_div.sv */
// ----------------------------------------------------------------------------
// rgbasat_div
// Four-lane restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rgbasat_div (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  rgbasat_pkg::lane_arr_t  dividend,
  input  logic [17:0]             divisor,
  output logic                    done,
  output rgbasat_pkg::lane_arr_t  quot
);
  import rgbasat_pkg::*;

  logic              busy;
  logic [4:0]        cnt;
  logic [AREA_W-1:0] dvs;
  logic [AREA_W-1:0] rem [NCH];
  lane_arr_t         dq;
  logic [AREA_W-1:0] rem_next [NCH];
  lane_arr_t         dq_next;
  logic [AREA_W:0]   trial [NCH];
  logic              ge [NCH];

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      trial[c]    = {rem[c], dq[c][LANE_W-1]};
      ge[c]       = trial[c] >= {1'b0, dvs};
      rem_next[c] = ge[c] ? AREA_W'(trial[c] - {1'b0, dvs}) : trial[c][AREA_W-1:0];
      dq_next[c]  = {dq[c][LANE_W-2:0], ge[c]};
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs <= divisor;
      dq  <= dividend;
      for (int c = 0; c < NCH; c++) begin
        rem[c] <= '0;
      end
    end else if (busy) begin
      dq <= dq_next;
      for (int c = 0; c < NCH; c++) begin
        rem[c] <= rem_next[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && !start && (cnt == 5'(DIV_STEPS - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign quot = dq;

endmodule

/* hw/rtl/rgbasat_back.sv */
// ----------------------------------------------------------------------------
// rgbasat_back
// Owns the table memory: builds entries on loads, walks corners on queries.
// ----------------------------------------------------------------------------
module rgbasat_back #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  rgbasat_pkg::cmd_t  q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        result_value,
  output logic [1:0]         status
);
  import rgbasat_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] STRIDE = AW'(MAX_WIDTH);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LD_RD  = 3'd1;
  localparam logic [2:0] S_LD_WR  = 3'd2;
  localparam logic [2:0] S_Q_RD   = 3'd3;
  localparam logic [2:0] S_FIN    = 3'd4;
  localparam logic [2:0] S_DSTART = 3'd5;
  localparam logic [2:0] S_DIV    = 3'd6;
  localparam logic [2:0] S_EMIT   = 3'd7;

  logic [NCH*LANE_W-1:0] mem [DEPTH];
  logic [NCH*LANE_W-1:0] rdata;
  logic [NCH*LANE_W-1:0] wdata;
  logic [AW-1:0]         raddr;
  logic [AW-1:0]         waddr;

  logic [2:0]        state;
  logic [2:0]        step;
  cmd_t              cur;
  lane_arr_t         acc;
  logic [RSUM_W-1:0] rsum [NCH];
  logic [RSUM_W-1:0] rsum_next [NCH];
  logic              p_acc;
  logic              p_zero;
  logic              p_neg;

  logic [CW-1:0] cx;
  logic [CW-1:0] cy;
  logic          cneg;
  logic [CW-1:0] rx;
  logic [CW-1:0] ry;
  logic          rzero;
  logic [2:0]    last_step;
  logic          out_free;
  logic          div_start;
  logic          div_done;
  lane_arr_t     quot;
  logic [31:0]   res;

  // corners: right/left of the first box, then of the wrapped part
  always_comb begin
    case (step)
      3'd0: begin cx = cur.xa1; cy = cur.y1; cneg = 1'b0; end
      3'd1: begin cx = cur.xa1; cy = cur.y0; cneg = 1'b1; end
      3'd2: begin cx = cur.x0;  cy = cur.y1; cneg = 1'b1; end
      3'd3: begin cx = cur.x0;  cy = cur.y0; cneg = 1'b0; end
      3'd4: begin cx = cur.xb1; cy = cur.y1; cneg = 1'b0; end
      3'd5: begin cx = cur.xb1; cy = cur.y0; cneg = 1'b1; end
      3'd6: begin cx = '0;      cy = cur.y1; cneg = 1'b1; end
      3'd7: begin cx = '0;      cy = cur.y0; cneg = 1'b0; end
      default: begin cx = '0; cy = '0; cneg = 1'b0; end
    endcase
    if (state == S_LD_RD) begin
      rx    = cur.x0;
      ry    = cur.y0 - 9'd1;
      rzero = (cur.y0 == '0);
    end else begin
      rx    = cx - 9'd1;
      ry    = cy - 9'd1;
      rzero = (cx == '0) || (cy == '0);
    end
    raddr = AW'(ry) * STRIDE + AW'(rx);
    waddr = AW'(cur.y0) * STRIDE + AW'(cur.x0);
  end

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      rsum_next[c] = ((cur.x0 == '0) ? '0 : rsum[c]) + RSUM_W'(cur.pixel[8*c +: 8]);
      wdata[LANE_W*c +: LANE_W] = (p_zero ? '0 : rdata[LANE_W*c +: LANE_W]) +
                                  LANE_W'(rsum_next[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_LD_WR) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  assign last_step = cur.split ? 3'd7 : 3'd3;
  assign out_free  = !out_valid || out_ready;
  assign q_pop     = (state == S_IDLE) && q_valid;
  assign div_start = (state == S_DSTART);

  always_comb begin
    if (cur.status != ST_OK) begin
      res = '0;
    end else if (cur.func == FUNC_AVG) begin
      res = {quot[3][7:0], quot[2][7:0], quot[1][7:0], quot[0][7:0]};
    end else begin
      res = 32'(acc[0]) + 32'(acc[1]) + 32'(acc[2]) + 32'(acc[3]);
    end
  end

  rgbasat_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (acc),
    .divisor  (cur.area),
    .done     (div_done),
    .quot     (quot)
  );

  // payload side
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
      acc <= '0;
    end else if (p_acc) begin
      for (int c = 0; c < NCH; c++) begin
        if (p_neg) begin
          acc[c] <= acc[c] - (p_zero ? '0 : rdata[LANE_W*c +: LANE_W]);
        end else begin
          acc[c] <= acc[c] + (p_zero ? '0 : rdata[LANE_W*c +: LANE_W]);
        end
      end
    end
    p_zero <= rzero;
    p_neg  <= cneg;
    if (state == S_EMIT && out_free) begin
      result_value <= res;
      status       <= cur.status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      p_acc     <= 1'b0;
      out_valid <= 1'b0;
      for (int c = 0; c < NCH; c++) begin
        rsum[c] <= '0;
      end
    end else begin
      // the corner read issued this cycle lands next cycle
      p_acc <= (state == S_Q_RD);
      if (out_valid && out_ready && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            step <= '0;
            if (q_data.func == FUNC_LOAD) begin
              state <= S_LD_RD;
            end else if (q_data.status != ST_OK) begin
              state <= S_EMIT;
            end else begin
              state <= S_Q_RD;
            end
          end
        end
        S_LD_RD: state <= S_LD_WR;
        S_LD_WR: begin
          for (int c = 0; c < NCH; c++) begin
            rsum[c] <= rsum_next[c];
          end
          state <= S_IDLE;
        end
        S_Q_RD: begin
          step <= step + 3'd1;
          if (step == last_step) begin
            state <= S_FIN;
          end
        end
        S_FIN: state <= (cur.func == FUNC_AVG) ? S_DSTART : S_EMIT;
        S_DSTART: state <= S_DIV;
        S_DIV: begin
          if (div_done) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* hw/rtl/rgba_summed_area_table_unit.sv */
// Per-channel summed-area tables over a region loaded pixel by pixel in raster
// order, with wrapping box queries. A load (func 0) is dequeued, then the table
// engine reads the entry above and writes the new entry. A sum query makes one
// table read per corner, for a box inside the region or one split at the right
// edge. An average query then runs the 24-step radix-2 divider, which sets the
// rate. Queries rejected with a nonzero status skip the table reads. A two-entry
// queue lets the front keep taking items while the table engine works or a
// result waits. Region size is written over the APB port (0x0 width, 0x4
// height); any write restarts loading at the top left corner.
`include "rgba_summed_area_table_unit_defines.svh"

// ----------------------------------------------------------------------------
// rgba_summed_area_table_unit
// Top level: register port, front classifier, command queue and table engine.
// ----------------------------------------------------------------------------
module rgba_summed_area_table_unit #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         func,
  input  logic [31:0]        pixel,
  input  logic signed [8:0]  query_x,
  input  logic [8:0]         query_y,
  input  logic [8:0]         query_width,
  input  logic [8:0]         query_height,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        result_value,
  output logic [1:0]         status
);
  import rgbasat_pkg::*;

  localparam int RESET_W = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
  localparam int RESET_H = (MAX_HEIGHT < 256) ? MAX_HEIGHT : 256;

  logic [8:0]  region_width;
  logic [8:0]  region_height;
  logic        cfg_wr;
  logic [8:0]  wv;
  logic [8:0]  w_sat;
  logic [8:0]  h_sat;
  logic        q_push;
  logic        q_pop;
  logic        q_full;
  logic        q_valid;
  cmd_t        q_wdata;
  cmd_t        q_rdata;
  front_stat_t fstat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign wv     = pwdata[8:0];
  assign prdata = paddr[2] ? {23'd0, region_height} : {23'd0, region_width};

  // zero becomes one, oversize clamps to the table bound
  always_comb begin
    if (wv == 9'd0) begin
      w_sat = 9'd1;
    end else if (32'(wv) > 32'(MAX_WIDTH)) begin
      w_sat = 9'(MAX_WIDTH);
    end else begin
      w_sat = wv;
    end
    if (wv == 9'd0) begin
      h_sat = 9'd1;
    end else if (32'(wv) > 32'(MAX_HEIGHT)) begin
      h_sat = 9'(MAX_HEIGHT);
    end else begin
      h_sat = wv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      region_width  <= 9'(RESET_W);
      region_height <= 9'(RESET_H);
    end else if (cfg_wr) begin
      if (paddr[2]) begin
        region_height <= h_sat;
      end else begin
        region_width <= w_sat;
      end
    end
  end

  rgbasat_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .func          (func),
    .pixel         (pixel),
    .query_x       (query_x),
    .query_y       (query_y),
    .query_width   (query_width),
    .query_height  (query_height),
    .region_width  (region_width),
    .region_height (region_height),
    .cfg_wr        (cfg_wr),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_data        (q_wdata),
    .stat          (fstat)
  );

  rgbasat_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  rgbasat_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_data       (q_rdata),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_value (result_value),
    .status       (status)
  );

  `RSAT_ASSERT_NXT(a_load_wrap, in_valid && in_ready && func == FUNC_LOAD, !fstat.loaded || (fstat.col == 9'd0 && fstat.row == 9'd0))
  `RSAT_ASSERT_NXT(a_cfg_restart, cfg_wr, !fstat.loaded && fstat.col == 9'd0 && fstat.row == 9'd0)
  `RSAT_ASSERT_IMP(a_err_zero, out_valid && status != ST_OK, result_value == 32'd0)

endmodule

/* dv/tb_rgba_summed_area_table_unit.sv */
// ----------------------------------------------------------------------------
// tb_rgba_summed_area_table_unit
// Streams pixel frames into the summed-area table unit over several region
// sizes and checks average and sum box queries, wrapping and error statuses,
// against a behavioral copy of the tables kept in the testbench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_rgba_summed_area_table_unit;
  import rgbasat_pkg::*;

  localparam int MAXW = 256;
  localparam int MAXH = 256;
  localparam logic [2:0] ADDR_WIDTH = 3'd0;
  localparam logic [2:0] ADDR_HEIGHT = 3'd4;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  stat;
  } box_result_t;

  typedef struct {
    logic [1:0]  fn;
    logic [31:0] pix;
    logic [8:0]  qx;
    logic [8:0]  qy;
    logic [8:0]  qw;
    logic [8:0]  qh;
    bit          has_exp;
    logic [31:0] exp_value;
    logic [1:0]  exp_stat;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] func = FUNC_LOAD;
  logic [31:0] pixel = '0;
  logic signed [8:0] query_x = '0;
  logic [8:0] query_y = '0, query_width = '0, query_height = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [31:0] result_value;
  logic [1:0] status;

  rgba_summed_area_table_unit dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [23:0] sat_tab [4][MAXW*MAXH];
  logic [15:0] row_acc [4];
  int unsigned reg_w, reg_h, cur_col, cur_row;
  bit frame_done;

  box_result_t expected_q[$];
  int mismatches = 0;
  bit hold_off = 1'b0;

  function automatic logic [23:0] corner_val(int c, int unsigned x, int unsigned y);
    if (x == 0 || y == 0) return '0;
    return sat_tab[c][(y-1)*MAXW + (x-1)];
  endfunction

  function automatic logic [23:0] box_total(int c, int unsigned x0, int unsigned y0,
                                            int unsigned x1, int unsigned y1);
    return corner_val(c, x1, y1) - corner_val(c, x1, y0) - corner_val(c, x0, y1)
           + corner_val(c, x0, y0);
  endfunction

  task automatic predict_write(logic [2:0] addr, logic [31:0] data);
    int unsigned v;
    v = data[8:0];
    if (v < 1) v = 1;
    if (addr == ADDR_WIDTH) reg_w = (v > MAXW) ? MAXW : v;
    else reg_h = (v > MAXH) ? MAXH : v;
    cur_col = 0;
    cur_row = 0;
    frame_done = 1'b0;
  endtask

  task automatic predict_item(logic [1:0] fn, logic [31:0] pix, logic [8:0] qxr,
                              logic [8:0] qy, logic [8:0] qw, logic [8:0] qh);
    int unsigned idx;
    int qx;
    logic [23:0] above, sums [4];
    logic [1:0] st;
    logic [31:0] res;
    int unsigned x1, area;
    if (fn == FUNC_LOAD) begin
      idx = cur_row*MAXW + cur_col;
      frame_done = 1'b0;
      for (int c = 0; c < 4; c++) begin
        row_acc[c] = (cur_col == 0 ? 16'd0 : row_acc[c]) + 16'(pix[8*c +: 8]);
        above = (cur_row > 0) ? sat_tab[c][idx-MAXW] : 24'd0;
        sat_tab[c][idx] = above + 24'(row_acc[c]);
      end
      cur_col++;
      if (cur_col >= reg_w) begin
        cur_col = 0;
        cur_row++;
        if (cur_row >= reg_h) begin
          cur_row = 0;
          frame_done = 1'b1;
        end
      end
      return;
    end
    if (fn == FUNC_RSVD) return;
    qx = $signed(qxr);
    if (qx < 0) qx += reg_w;
    st = ST_OK;
    res = '0;
    if (!frame_done) st = ST_NOT_LOADED;
    else if (qw == 0 || qh == 0) st = ST_ZERO_AREA;
    else if (qx < 0 || qx >= reg_w || qw > reg_w || qy + qh > reg_h) st = ST_RANGE;
    if (st == ST_OK) begin
      x1 = qx + qw;
      for (int c = 0; c < 4; c++) begin
        if (x1 <= reg_w) sums[c] = box_total(c, qx, qy, x1, qy + qh);
        else sums[c] = box_total(c, qx, qy, reg_w, qy + qh)
                       + box_total(c, 0, qy, x1 - reg_w, qy + qh);
      end
      if (fn == FUNC_AVG) begin
        area = qw * qh;
        for (int c = 0; c < 4; c++) res[8*c +: 8] = 8'(32'(sums[c]) / area);
      end else begin
        res = 32'(sums[0]) + 32'(sums[1]) + 32'(sums[2]) + 32'(sums[3]);
      end
    end
    expected_q.push_back('{value: res, stat: st});
  endtask

  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    predict_write(addr, data);
  endtask

  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    // a load may still be in the table engine
    repeat (20) @(posedge clk);
  endtask

  // one beat on the input side; the expectation is queued before the beat lands
  // valid stays up after the beat until a gap or the next beat replaces it
  task automatic send_beat(logic [1:0] fn, logic [31:0] pix, logic [8:0] qx,
                           logic [8:0] qy, logic [8:0] qw, logic [8:0] qh, bit gaps);
    int n;
    n = gaps ? $urandom_range(0, 5) : 0;
    if (n != 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    predict_item(fn, pix, qx, qy, qw, qh);
    in_valid <= 1'b1; func <= fn; pixel <= pix;
    query_x <= qx; query_y <= qy; query_width <= qw; query_height <= qh;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic load_frame(bit gaps);
    int n;
    n = reg_w * reg_h;
    for (int i = 0; i < n; i++) send_beat(FUNC_LOAD, $urandom(), '0, '0, '0, '0, gaps);
  endtask

  task automatic rand_query(bit gaps);
    logic [1:0] fn;
    logic [8:0] qx, qy, qw, qh;
    fn = ($urandom_range(0, 1) != 0) ? FUNC_AVG : FUNC_SUM;
    if ($urandom_range(0, 9) < 8) begin
      qw = 9'($urandom_range(1, reg_w));
      qh = 9'($urandom_range(1, reg_h));
      qy = 9'($urandom_range(0, reg_h - qh));
      qx = ($urandom_range(0, 3) == 0) ? 9'(-$urandom_range(1, reg_w))
                                       : 9'($urandom_range(0, reg_w - 1));
    end else begin
      qx = 9'($urandom()); qy = 9'($urandom()); qw = 9'($urandom()); qh = 9'($urandom());
      if ($urandom_range(0, 3) == 0) fn = FUNC_RSVD;
    end
    send_beat(fn, $urandom(), qx, qy, qw, qh, gaps);
  endtask

  // receiver
  always @(posedge clk) begin
    box_result_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: value %h status %0d",
                                       result_value, status);
      end else begin
        e = expected_q.pop_front();
        if (result_value !== e.value || status !== e.stat) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected value %h status %0d, got value %h status %0d",
                     e.value, e.stat, result_value, status);
        end
      end
    end
  end

  initial begin
    int w;
    forever begin
      @(posedge clk);
      if (hold_off) out_ready <= 1'b0;
      else if (out_ready && out_valid) begin
        w = $urandom_range(0, 5);
        if (w != 0) begin
          out_ready <= 1'b0;
          repeat (w) @(posedge clk);
        end
        out_ready <= 1'b1;
      end else out_ready <= 1'b1;
    end
  end

  initial begin
    #50ms;
    $display("tb_rgba_summed_area_table_unit: FAIL");
    $finish;
  end

  initial begin
    stim_row_t dir [$];
    int sizes [6][2];
    int frames;
    reg_w = MAXW; reg_h = MAXH; cur_col = 0; cur_row = 0; frame_done = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // not loaded right after reset
    dir.push_back('{FUNC_AVG, 32'h0, 9'd0, 9'd0, 9'd1, 9'd1, 1'b1, 32'h0, ST_NOT_LOADED});
    dir.push_back('{FUNC_SUM, 32'h0, 9'd0, 9'd0, 9'd1, 9'd1, 1'b1, 32'h0, ST_NOT_LOADED});
    dir.push_back('{FUNC_RSVD, 32'h0, 9'd0, 9'd0, 9'd1, 9'd1, 1'b0, 32'h0, ST_OK});
    foreach (dir[i]) begin
      send_beat(dir[i].fn, dir[i].pix, dir[i].qx, dir[i].qy, dir[i].qw, dir[i].qh, 1'b1);
      if (dir[i].has_exp && expected_q.size() != 0 &&
          (expected_q[$].value !== dir[i].exp_value || expected_q[$].stat !== dir[i].exp_stat))
        mismatches++;
    end
    drain_and_settle();

    // small 4x3 region with extreme pixels, then directed queries
    reg_write(ADDR_WIDTH, 32'd4);
    reg_write(ADDR_HEIGHT, 32'd3);
    for (int i = 0; i < 12; i++)
      send_beat(FUNC_LOAD, (i % 2) ? 32'hffffffff : 32'h0, '0, '0, '0, '0, 1'b1);
    dir.delete();
    dir.push_back('{FUNC_AVG, 32'h0, 9'd0, 9'd0, 9'd0, 9'd1, 1'b1, 32'h0, ST_ZERO_AREA});
    dir.push_back('{FUNC_SUM, 32'h0, 9'd0, 9'd0, 9'd1, 9'd0, 1'b1, 32'h0, ST_ZERO_AREA});
    dir.push_back('{FUNC_SUM, 32'h0, 9'd4, 9'd0, 9'd1, 9'd1, 1'b1, 32'h0, ST_RANGE});
    dir.push_back('{FUNC_SUM, 32'h0, 9'd0, 9'd0, 9'd5, 9'd1, 1'b1, 32'h0, ST_RANGE});
    dir.push_back('{FUNC_SUM, 32'h0, 9'd0, 9'd1, 9'd1, 9'd3, 1'b1, 32'h0, ST_RANGE});
    dir.push_back('{FUNC_AVG, 32'h0, 9'h100, 9'd0, 9'd1, 9'd1, 1'b1, 32'h0, ST_RANGE});
    dir.push_back('{FUNC_AVG, 32'h0, 9'd1, 9'd0, 9'd1, 9'd1, 1'b1, 32'hffffffff, ST_OK});
    dir.push_back('{FUNC_SUM, 32'h0, 9'd0, 9'd0, 9'd4, 9'd3, 1'b1, 32'd6120, ST_OK});
    dir.push_back('{FUNC_AVG, 32'h0, 9'h1ff, 9'd1, 9'd2, 9'd2, 1'b0, 32'h0, ST_OK});
    dir.push_back('{FUNC_SUM, 32'h0, 9'd3, 9'd0, 9'd4, 9'd3, 1'b0, 32'h0, ST_OK});
    dir.push_back('{FUNC_AVG, 32'h0, 9'h1fc, 9'd2, 9'd3, 9'd1, 1'b0, 32'h0, ST_OK});
    dir.push_back('{FUNC_SUM, 32'hffffffff, 9'hff, 9'h100, 9'h100, 9'h100, 1'b0, 32'h0, ST_OK});
    dir.push_back('{FUNC_RSVD, 32'hffffffff, 9'h1ff, 9'h1ff, 9'h1ff, 9'h1ff, 1'b0, 32'h0, ST_OK});
    foreach (dir[i]) begin
      send_beat(dir[i].fn, dir[i].pix, dir[i].qx, dir[i].qy, dir[i].qw, dir[i].qh, 1'b1);
      if (dir[i].has_exp &&
          (expected_q[$].value !== dir[i].exp_value || expected_q[$].stat !== dir[i].exp_stat)) begin
        mismatches++;
        $display("directed row %0d predicts %h/%0d", i, expected_q[$].value, expected_q[$].stat);
      end
    end
    // a load in the middle of a frame drops the loaded flag
    send_beat(FUNC_LOAD, 32'h12345678, '0, '0, '0, '0, 1'b1);
    send_beat(FUNC_SUM, 32'h0, 9'd0, 9'd0, 9'd1, 9'd1, 1'b1);
    drain_and_settle();

    // random phases over several region sizes, extremes included
    sizes = '{'{1, 1}, '{256, 1}, '{1, 256}, '{0, 300}, '{7, 5}, '{16, 9}};
    foreach (sizes[s]) begin
      reg_write(ADDR_WIDTH, sizes[s][0]);
      reg_write(ADDR_HEIGHT, sizes[s][1]);
      // large regions get one frame to keep the run short
      frames = (reg_w * reg_h > 64) ? 1 : 2;
      for (int f = 0; f < frames; f++) begin
        load_frame(reg_w * reg_h < 64);
        for (int q = 0; q < 40; q++) rand_query(1'b1);
        if (s == 4 && f == 0) begin
          // receiver holds off while the sender keeps going
          hold_off = 1'b1;
          fork
            begin repeat (300) @(posedge clk); hold_off = 1'b0; end
            for (int q = 0; q < 20; q++) rand_query(1'b0);
          join
          // sender waits for everything outstanding
          in_valid <= 1'b0;
          while (expected_q.size() != 0) @(posedge clk);
        end
        for (int q = 0; q < 40; q++) rand_query(q < 20);
      end
      drain_and_settle();
    end

    if (mismatches == 0) $display("tb_rgba_summed_area_table_unit: PASS");
    else $display("tb_rgba_summed_area_table_unit: FAIL");
    $finish;
  end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/rgbasat_pkg.sv
hw/rtl/rgbasat_front.sv
hw/rtl/rgbasat_fifo.sv
hw/rtl/rgbasat_div.sv
hw/rtl/rgbasat_back.sv
hw/rtl/rgba_summed_area_table_unit.sv
dv/tb_rgba_summed_area_table_unit.sv
